// ===== hw/rtl/window_3x3_median_average_filter_top_macros.svh =====
`ifndef WINDOW_3X3_MEDIAN_AVERAGE_FILTER_TOP_MACROS_SVH
`define WINDOW_3X3_MEDIAN_AVERAGE_FILTER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define W3MAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define W3MAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define W3MAF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/w3maf_pkg.sv =====
`default_nettype none
package w3maf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam int LANES      = 4;
  localparam int DEPTH_LANE = 3;
  localparam int SAMPLE_W   = 24;
  localparam int KEY_W      = 17;
  localparam int SUM_W      = 20;
  localparam int ABS_W      = 19;

  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam int RECIP9    = 466034;
  localparam int RECIP9_SH = 22;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_DEPTH_FLOOR
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_COLOR_MEDIAN,
    MODE_COLOR_AVERAGE,
    MODE_DEPTH_AVERAGE,
    MODE_DEPTH_MEDIAN
  } mode_t;

  typedef logic [SAMPLE_W-1:0]     sample_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } column_t;

  typedef struct packed {
    column_t                         raw;
    logic [LANES-1:0][KEY_W-1:0]     lo;
    logic [LANES-1:0][KEY_W-1:0]     md;
    logic [LANES-1:0][KEY_W-1:0]     hi;
    logic [LANES-1:0][SUM_W-1:0]     csum;
  } cell_out_t;

  function automatic logic is_color(mode_t m);
    return !m[1];
  endfunction

  function automatic key_t lane_key(sample_t s, int lane);
    key_t k;
    if (lane == DEPTH_LANE) begin
      k = {s[15], s[15:0]};
    end else begin
      k = {9'b0, s[8*lane +: 8]};
    end
    return k;
  endfunction

  function automatic key_t max2(key_t a, key_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic key_t min2(key_t a, key_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic key_t max3(key_t a, key_t b, key_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic key_t min3(key_t a, key_t b, key_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic key_t med3(key_t a, key_t b, key_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/w3maf_ram.sv =====
`default_nettype none
module w3maf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/w3maf_cell.sv =====
`default_nettype none
module w3maf_cell (
  input  logic                  clk,
  input  logic                  shift_en,
  input  w3maf_pkg::column_t    col_in,
  output w3maf_pkg::cell_out_t  cell_out
);

  w3maf_pkg::column_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    w3maf_pkg::key_t kt;
    w3maf_pkg::key_t km;
    w3maf_pkg::key_t kb;
    cell_out.raw = col_r;
    for (int l = 0; l < w3maf_pkg::LANES; l++) begin
      kt = w3maf_pkg::lane_key(col_r.top, l);
      km = w3maf_pkg::lane_key(col_r.mid, l);
      kb = w3maf_pkg::lane_key(col_r.bot, l);
      cell_out.lo[l]   = w3maf_pkg::min3(kt, km, kb);
      cell_out.md[l]   = w3maf_pkg::med3(kt, km, kb);
      cell_out.hi[l]   = w3maf_pkg::max3(kt, km, kb);
      cell_out.csum[l] = w3maf_pkg::SUM_W'(kt) + w3maf_pkg::SUM_W'(km)
                         + w3maf_pkg::SUM_W'(kb);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/window_3x3_median_average_filter_top.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | in_color, in_depth
// out     | output    | out_valid / out_stall | out_color_out, out_depth_out,
//         |           |                       | out_column, out_row, out_frame_end
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per clock is taken while in_stall is low. Throughput is bounded by
// the output: one result per cycle while out_stall is low, up to three per pixel
// at row ends and on the last row, buffered in an eight-entry result queue.
// in_stall rises while eight pixels sit between the input and the output register.
// rst_n is synchronous; the line store and window hold no reset.
`default_nettype none
module window_3x3_median_average_filter_top #(
  parameter int MAX_WIDTH  = w3maf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = w3maf_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [23:0]             in_color,
  input  logic signed [15:0]      in_depth,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [23:0]             out_color_out,
  output logic signed [15:0]      out_depth_out,
  output logic [COL_W-1:0]        out_column,
  output logic [ROW_W-1:0]        out_row,
  output logic                    out_frame_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int LANES = w3maf_pkg::LANES;
  localparam int KEY_W = w3maf_pkg::KEY_W;
  localparam int SUM_W = w3maf_pkg::SUM_W;
  localparam int ABS_W = w3maf_pkg::ABS_W;
  localparam int SW    = w3maf_pkg::SAMPLE_W;
  localparam int FAW   = w3maf_pkg::FIFO_AW;
  localparam int P3_W  = 20;
  localparam int P9_W  = 2 * ABS_W;

  typedef struct packed {
    logic has_a;
    logic filt_a;
    logic has_b;
    logic has_c;
    logic end_c;
  } flags_t;

  typedef struct packed {
    w3maf_pkg::sample_t val_a;
    w3maf_pkg::sample_t val_b;
    w3maf_pkg::sample_t val_c;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [2:0]         mask;
    logic               end_c;
  } bundle_t;

  // configuration
  w3maf_pkg::mode_t   mode_r;
  logic [11:0]        fw_r;
  logic [12:0]        fh_r;
  logic signed [15:0] floor_r;
  logic               cfg_we;
  logic               restart;
  logic [COL_W-1:0]   col_last;
  logic [ROW_W-1:0]   row_last;
  logic               color_mode;

  // position counters
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               accept;
  flags_t             s0_flags;

  // stage 1
  logic               s1_valid_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [ROW_W-1:0]   s1_row_r;
  w3maf_pkg::sample_t s1_cur_r;
  flags_t             s1_flags_r;
  logic               byp_hit_r;
  logic [2*SW-1:0]    byp_data_r;
  logic [2*SW-1:0]    ram_q;
  logic [2*SW-1:0]    ram_rd;
  logic [2*SW-1:0]    ram_wdata;
  w3maf_pkg::column_t new_col;

  w3maf_pkg::cell_out_t c0, c1, c2;

  // stage 2
  logic               s2_valid_r;
  logic [COL_W-1:0]   s2_col_r;
  logic [ROW_W-1:0]   s2_row_r;
  flags_t             s2_flags_r;
  logic [LANES-1:0][KEY_W-1:0] s2_lo, s2_md, s2_hi, s2_ctr;
  logic [LANES-1:0][SUM_W-1:0] s2_sum;

  // stage 3
  logic               s3_valid_r;
  logic [COL_W-1:0]   s3_col_r;
  logic [ROW_W-1:0]   s3_row_r;
  flags_t             s3_flags_r;
  logic [LANES-1:0][KEY_W-1:0] s3_lo_r, s3_md_r, s3_hi_r, s3_ctr_r;
  logic [LANES-1:0][SUM_W-1:0] s3_sum_r;
  w3maf_pkg::sample_t s3_center_r, s3_right_r, s3_cur_r;
  logic [LANES-1:0][KEY_W-1:0] s3_med;
  logic [2:0][7:0]    s3_avg;
  logic [KEY_W-1:0]   s3_q9;
  logic               s3_neg;

  // stage 4
  logic               s4_valid_r;
  logic [COL_W-1:0]   s4_col_r;
  logic [ROW_W-1:0]   s4_row_r;
  flags_t             s4_flags_r;
  logic [LANES-1:0][KEY_W-1:0] s4_med_r;
  logic [2:0][7:0]    s4_avg_r;
  logic [KEY_W-1:0]   s4_q9_r;
  logic               s4_neg_r;
  w3maf_pkg::sample_t s4_center_r, s4_right_r, s4_cur_r;
  bundle_t            s4_bundle;
  logic               push, drop;

  // result queue and output register
  bundle_t            fifo_mem [w3maf_pkg::FIFO_DEPTH];
  logic [FAW-1:0]     wptr_r, rptr_r;
  logic [FAW:0]       fcnt_r, fcnt_nxt;
  logic [FAW:0]       cnt_r, cnt_nxt;
  bundle_t            head;
  bundle_t            ob_r;
  logic [2:0]         om_r, om_nxt, om_left, lowbit;
  logic               xfer, load;
  w3maf_pkg::sample_t out_val;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign color_mode = w3maf_pkg::is_color(mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= w3maf_pkg::MODE_COLOR_MEDIAN;
      fw_r    <= 12'd2048;
      fh_r    <= 13'd4096;
      floor_r <= 16'sh8000;
    end else if (cfg_we) begin
      case (w3maf_pkg::reg_idx_t'(cfg_index))
        w3maf_pkg::REG_MODE:         mode_r  <= w3maf_pkg::mode_t'(cfg_data[1:0]);
        w3maf_pkg::REG_FRAME_WIDTH:  fw_r    <= cfg_data[11:0];
        w3maf_pkg::REG_FRAME_HEIGHT: fh_r    <= cfg_data[12:0];
        w3maf_pkg::REG_DEPTH_FLOOR:  floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (w3maf_pkg::reg_idx_t'(cfg_index) != w3maf_pkg::REG_DEPTH_FLOOR);

  always_comb begin
    if (fw_r == '0) begin
      col_last = '0;
    end else if (32'(fw_r) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(fw_r - 12'd1);
    end
    if (fh_r == '0) begin
      row_last = '0;
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(fh_r - 13'd1);
    end
  end

  assign in_stall = (cnt_r == (FAW+1)'(w3maf_pkg::FIFO_DEPTH));
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    s0_flags.has_a  = (row_r != '0) && (col_r != '0);
    s0_flags.filt_a = (row_r > ROW_W'(1)) && (col_r > COL_W'(1));
    s0_flags.has_b  = (row_r != '0) && (col_r == col_last);
    s0_flags.has_c  = (row_r == row_last);
    s0_flags.end_c  = (col_r == col_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read returns, window column enters the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_col_r   <= col_r;
    s1_row_r   <= row_r;
    s1_cur_r   <= color_mode ? in_color : {8'b0, in_depth};
    s1_flags_r <= s0_flags;
    byp_hit_r  <= s1_valid_r && (col_r == s1_col_r);
    byp_data_r <= ram_wdata;
  end

  assign ram_rd    = byp_hit_r ? byp_data_r : ram_q;
  assign ram_wdata = {s1_cur_r, ram_rd[2*SW-1:SW]};
  assign new_col   = '{top: ram_rd[SW-1:0], mid: ram_rd[2*SW-1:SW], bot: s1_cur_r};

  w3maf_ram #(
    .WIDTH(2 * SW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_col_r),
    .wdata(ram_wdata),
    .raddr(col_r),
    .rdata(ram_q)
  );

  w3maf_cell u_cell0 (.clk(clk), .shift_en(s1_valid_r), .col_in(new_col),  .cell_out(c0));
  w3maf_cell u_cell1 (.clk(clk), .shift_en(s1_valid_r), .col_in(c0.raw),   .cell_out(c1));
  w3maf_cell u_cell2 (.clk(clk), .shift_en(s1_valid_r), .col_in(c1.raw),   .cell_out(c2));

  // stage 2: combine the three sorted columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_col_r   <= s1_col_r;
    s2_row_r   <= s1_row_r;
    s2_flags_r <= s1_flags_r;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s2_lo[l]  = w3maf_pkg::max3(c0.lo[l], c1.lo[l], c2.lo[l]);
      s2_md[l]  = w3maf_pkg::med3(c0.md[l], c1.md[l], c2.md[l]);
      s2_hi[l]  = w3maf_pkg::min3(c0.hi[l], c1.hi[l], c2.hi[l]);
      s2_ctr[l] = w3maf_pkg::lane_key(c1.raw.mid, l);
      s2_sum[l] = c0.csum[l] + c1.csum[l] + c2.csum[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_col_r    <= s2_col_r;
    s3_row_r    <= s2_row_r;
    s3_flags_r  <= s2_flags_r;
    s3_lo_r     <= s2_lo;
    s3_md_r     <= s2_md;
    s3_hi_r     <= s2_hi;
    s3_ctr_r    <= s2_ctr;
    s3_sum_r    <= s2_sum;
    s3_center_r <= c1.raw.mid;
    s3_right_r  <= c0.raw.mid;
    s3_cur_r    <= c0.raw.bot;
  end

  // stage 3: medians, divide by 12 and by 9
  always_comb begin
    logic signed [SUM_W-1:0] wsum;
    logic signed [SUM_W-1:0] ctr_x;
    logic signed [SUM_W-1:0] dsum;
    logic [ABS_W-1:0]        mag;
    logic [P3_W-1:0]         prod3;
    logic [P9_W-1:0]         prod9;
    for (int l = 0; l < LANES; l++) begin
      s3_med[l] = w3maf_pkg::med3(s3_lo_r[l], s3_md_r[l], s3_hi_r[l]);
    end
    for (int l = 0; l < 3; l++) begin
      ctr_x     = SUM_W'(w3maf_pkg::key_t'(s3_ctr_r[l]));
      wsum      = signed'(s3_sum_r[l]) + (ctr_x <<< 1) + ctr_x;
      prod3     = P3_W'(wsum[11:2]) * P3_W'(w3maf_pkg::RECIP3);
      s3_avg[l] = prod3[w3maf_pkg::RECIP3_SH +: 8];
    end
    dsum   = signed'(s3_sum_r[w3maf_pkg::DEPTH_LANE]);
    s3_neg = dsum[SUM_W-1];
    mag    = ABS_W'(s3_neg ? -dsum : dsum);
    prod9  = P9_W'(mag) * P9_W'(w3maf_pkg::RECIP9);
    s3_q9  = prod9[w3maf_pkg::RECIP9_SH +: KEY_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_col_r    <= s3_col_r;
    s4_row_r    <= s3_row_r;
    s4_flags_r  <= s3_flags_r;
    s4_med_r    <= s3_med;
    s4_avg_r    <= s3_avg;
    s4_q9_r     <= s3_q9;
    s4_neg_r    <= s3_neg;
    s4_center_r <= s3_center_r;
    s4_right_r  <= s3_right_r;
    s4_cur_r    <= s3_cur_r;
  end

  // stage 4: threshold, border values, pack the result bundle
  always_comb begin
    w3maf_pkg::key_t    dq;
    w3maf_pkg::key_t    dres;
    w3maf_pkg::key_t    dfloor;
    logic [15:0]        dval;
    w3maf_pkg::sample_t filt;
    dq     = s4_neg_r ? -w3maf_pkg::key_t'(s4_q9_r) : w3maf_pkg::key_t'(s4_q9_r);
    dres   = (mode_r == w3maf_pkg::MODE_DEPTH_AVERAGE) ? dq
             : w3maf_pkg::key_t'(s4_med_r[w3maf_pkg::DEPTH_LANE]);
    dfloor = {floor_r[15], floor_r};
    dval   = (dres < dfloor) ? s4_center_r[15:0] : dres[15:0];
    case (mode_r)
      w3maf_pkg::MODE_COLOR_MEDIAN:
        filt = {s4_med_r[2][7:0], s4_med_r[1][7:0], s4_med_r[0][7:0]};
      w3maf_pkg::MODE_COLOR_AVERAGE:
        filt = {s4_avg_r[2], s4_avg_r[1], s4_avg_r[0]};
      default:
        filt = {8'b0, dval};
    endcase
    s4_bundle.val_a = s4_flags_r.filt_a ? filt
                      : (color_mode ? '0 : {8'b0, s4_center_r[15:0]});
    s4_bundle.val_b = color_mode ? '0 : {8'b0, s4_right_r[15:0]};
    s4_bundle.val_c = color_mode ? '0 : {8'b0, s4_cur_r[15:0]};
    s4_bundle.col   = s4_col_r;
    s4_bundle.row   = s4_row_r;
    s4_bundle.mask  = {s4_flags_r.has_c, s4_flags_r.has_b, s4_flags_r.has_a};
    s4_bundle.end_c = s4_flags_r.end_c;
  end

  assign push = s4_valid_r && (s4_bundle.mask != '0);
  assign drop = s4_valid_r && (s4_bundle.mask == '0);

  // result queue
  assign head = fifo_mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wptr_r] <= s4_bundle;
    end
  end

  // output register: emit the pending results of one bundle, lowest first
  assign xfer    = out_valid & ~out_stall;
  assign lowbit  = om_r & (~om_r + 3'd1);
  assign om_left = xfer ? (om_r & ~lowbit) : om_r;
  assign load    = (om_left == '0) && (fcnt_r != '0);
  assign om_nxt  = load ? head.mask : om_left;

  always_comb begin
    fcnt_nxt = fcnt_r + (FAW+1)'(push) - (FAW+1)'(load);
    cnt_nxt  = cnt_r + (FAW+1)'(accept) - (FAW+1)'(drop) - (FAW+1)'(load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fcnt_r <= '0;
      cnt_r  <= '0;
      om_r   <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FAW'(1);
      end
      if (load) begin
        rptr_r <= rptr_r + FAW'(1);
      end
      fcnt_r <= fcnt_nxt;
      cnt_r  <= cnt_nxt;
      om_r   <= om_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= head;
    end
  end

  always_comb begin
    out_valid     = (om_r != '0);
    out_frame_end = 1'b0;
    if (om_r[0]) begin
      out_val    = ob_r.val_a;
      out_column = ob_r.col - COL_W'(1);
      out_row    = ob_r.row - ROW_W'(1);
    end else if (om_r[1]) begin
      out_val    = ob_r.val_b;
      out_column = ob_r.col;
      out_row    = ob_r.row - ROW_W'(1);
    end else begin
      out_val       = ob_r.val_c;
      out_column    = ob_r.col;
      out_row       = ob_r.row;
      out_frame_end = ob_r.end_c;
    end
    out_color_out = color_mode ? out_val : '0;
    out_depth_out = color_mode ? '0 : out_val[15:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/w3maf_chk.sv =====
`default_nettype none
`include "window_3x3_median_average_filter_top_macros.svh"
module w3maf_chk #(
  parameter int MAX_WIDTH  = w3maf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = w3maf_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [23:0]        in_color,
  input logic signed [15:0] in_depth,
  input logic               out_valid,
  input logic               out_stall,
  input logic [23:0]        out_color_out,
  input logic signed [15:0] out_depth_out,
  input logic [COL_W-1:0]   out_column,
  input logic [ROW_W-1:0]   out_row,
  input logic               out_frame_end,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  logic [40+COL_W+ROW_W:0] out_word;

  assign out_word = {out_color_out, out_depth_out, out_column, out_row, out_frame_end};

  `W3MAF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")
  `W3MAF_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && !in_stall, "not clear after reset")
  `W3MAF_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind window_3x3_median_average_filter_top w3maf_chk #(
  .MAX_WIDTH (MAX_WIDTH),
  .MAX_HEIGHT(MAX_HEIGHT)
) u_w3maf_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  typedef enum logic [1:0] {K_PIX, K_CFG, K_SYNC} job_kind_t;

  typedef struct {
    job_kind_t            kind;
    logic [23:0]          color;
    logic [15:0]          depth;
    w3maf_pkg::reg_idx_t  idx;
    logic [15:0]          data;
  } job_t;

  typedef struct {
    logic [23:0]        color;
    logic signed [15:0] depth;
    logic [10:0]        column;
    logic [11:0]        row;
    logic               fend;
  } pix_result_t;

  localparam int SETTLE   = 20;
  localparam int WD_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] in_color = '0;
  logic signed [15:0] in_depth = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] out_color_out;
  logic signed [15:0] out_depth_out;
  logic [10:0] out_column;
  logic [11:0] out_row;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  w3maf_pkg::reg_idx_t cfg_index = w3maf_pkg::REG_MODE;
  logic [15:0] cfg_data = '0;

  window_3x3_median_average_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_color(in_color), .in_depth(in_depth),
    .out_valid(out_valid), .out_stall(out_stall), .out_color_out(out_color_out),
    .out_depth_out(out_depth_out), .out_column(out_column), .out_row(out_row),
    .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_t        jobs[$];
  pix_result_t pending_results[$];
  int          errors = 0;
  int          pix_sent = 0;

  w3maf_pkg::mode_t   f_mode = w3maf_pkg::MODE_COLOR_MEDIAN;
  logic [11:0]        f_width = 12'd2048;
  logic [12:0]        f_height = 13'd4096;
  logic signed [15:0] f_floor = 16'sh8000;
  logic [23:0]        f_lines[2*2048];
  logic [23:0]        f_win[3][3];
  int                 f_col = 0;
  int                 f_row = 0;

  function automatic bit color_mode();
    return f_mode == w3maf_pkg::MODE_COLOR_MEDIAN || f_mode == w3maf_pkg::MODE_COLOR_AVERAGE;
  endfunction

  function automatic int median_of9(int v[9]);
    int i, j, x;
    for (i = 1; i < 9; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > x) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = x;
    end
    return v[4];
  endfunction

  function automatic logic [23:0] window_filter();
    int v[9];
    int i, ch, s, r;
    logic [23:0] res;
    logic signed [15:0] d;
    res = '0;
    if (color_mode()) begin
      for (ch = 0; ch < 3; ch++) begin
        for (i = 0; i < 9; i++) v[i] = f_win[i/3][i%3][8*ch +: 8];
        if (f_mode == w3maf_pkg::MODE_COLOR_MEDIAN) begin
          r = median_of9(v);
        end else begin
          s = 3 * v[4];
          for (i = 0; i < 9; i++) s += v[i];
          r = s / 12;
        end
        res[8*ch +: 8] = r[7:0];
      end
    end else begin
      for (i = 0; i < 9; i++) begin
        d = f_win[i/3][i%3][15:0];
        v[i] = d;
      end
      if (f_mode == w3maf_pkg::MODE_DEPTH_AVERAGE) begin
        s = 0;
        for (i = 0; i < 9; i++) s += v[i];
        r = s / 9;
      end else begin
        r = median_of9(v);
      end
      if (r < int'(f_floor)) r = v[4];
      d = f_win[1][1][15:0];
      if (r < int'(f_floor)) r = d;
      res = {8'h00, r[15:0]};
    end
    return res;
  endfunction

  function automatic logic [23:0] edge_value(logic [23:0] s);
    return color_mode() ? 24'h0 : {8'h00, s[15:0]};
  endfunction

  task automatic post_result(logic [23:0] v, int c, int r, bit fe);
    pix_result_t e;
    e.color = color_mode() ? v : 24'h0;
    e.depth = color_mode() ? 16'sh0 : v[15:0];
    e.column = c[10:0];
    e.row = r[11:0];
    e.fend = fe;
    pending_results.push_back(e);
  endtask

  task automatic filter_pixel(logic [23:0] cin, logic [15:0] din);
    int w, h, c, r, bc, bp, i;
    logic [23:0] cur, v;
    w = (f_width == 0) ? 1 : (f_width > 2048) ? 2048 : f_width;
    h = (f_height == 0) ? 1 : (f_height > 4096) ? 4096 : f_height;
    if (f_col >= w) begin
      f_col = 0;
      f_row++;
    end
    if (f_row >= h) f_row = 0;
    c = f_col;
    r = f_row;
    cur = color_mode() ? cin : {8'h00, din};
    bc = (r % 2) * 2048;
    bp = ((r + 1) % 2) * 2048;
    for (i = 0; i < 3; i++) begin
      f_win[i][0] = f_win[i][1];
      f_win[i][1] = f_win[i][2];
    end
    f_win[0][2] = f_lines[bc + c];
    f_win[1][2] = f_lines[bp + c];
    f_win[2][2] = cur;
    f_lines[bc + c] = cur;
    if (r >= 1 && c >= 1) begin
      v = (r >= 2 && c >= 2) ? window_filter() : edge_value(f_win[1][1]);
      post_result(v, c - 1, r - 1, 1'b0);
    end
    if (r >= 1 && c == w - 1) post_result(edge_value(f_win[1][2]), c, r - 1, 1'b0);
    if (r == h - 1) post_result(edge_value(cur), c, r, c == w - 1);
    f_col = c + 1;
    if (f_col >= w) begin
      f_col = 0;
      f_row = r + 1;
      if (f_row >= h) f_row = 0;
    end
  endtask

  task automatic apply_write(w3maf_pkg::reg_idx_t idx, logic [15:0] data);
    case (idx)
      w3maf_pkg::REG_MODE: f_mode = w3maf_pkg::mode_t'(data[1:0]);
      w3maf_pkg::REG_FRAME_WIDTH: f_width = data[11:0];
      w3maf_pkg::REG_FRAME_HEIGHT: f_height = data[12:0];
      w3maf_pkg::REG_DEPTH_FLOOR: f_floor = data;
      default: ;
    endcase
    if (idx != w3maf_pkg::REG_DEPTH_FLOOR) begin
      f_col = 0;
      f_row = 0;
    end
  endtask

  // driver
  bit in_xfer, cfg_xfer, busy, calm;
  bit nxt_in_valid, nxt_cfg_valid;
  int gap = 0;
  int settle = 0;
  job_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_xfer = in_valid && !in_stall;
      cfg_xfer = cfg_valid && cfg_ready;
      calm = jobs.size() < 40;
      if (in_xfer) begin
        filter_pixel(in_color, in_depth);
        pix_sent++;
      end
      if (cfg_xfer) apply_write(cfg_index, cfg_data);
      if (in_xfer || in_valid || pending_results.size() != 0) settle <= 0;
      else settle <= settle + 1;
      busy = (in_valid && !in_xfer) || (cfg_valid && !cfg_xfer);
      if (!busy) begin
        nxt_in_valid = 1'b0;
        nxt_cfg_valid = 1'b0;
        if (gap > 0) begin
          gap--;
        end else if (jobs.size() > 0) begin
          head = jobs[0];
          if (head.kind == K_PIX) begin
            void'(jobs.pop_front());
            nxt_in_valid = 1'b1;
            in_color <= head.color;
            in_depth <= head.depth;
            if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
          end else if (!in_valid && !cfg_valid && !in_xfer && settle >= SETTLE) begin
            void'(jobs.pop_front());
            if (head.kind == K_CFG) begin
              nxt_cfg_valid = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.data;
            end
          end
        end
        in_valid <= nxt_in_valid;
        cfg_valid <= nxt_cfg_valid;
      end
    end
  end

  // monitor
  int sgap = 0;
  int hold_left = 0;
  bit held = 0;
  pix_result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result col=%0d row=%0d", out_column, out_row);
        end else begin
          want = pending_results.pop_front();
          if (out_color_out !== want.color || out_depth_out !== want.depth ||
              out_column !== want.column || out_row !== want.row ||
              out_frame_end !== want.fend) begin
            errors++;
            if (errors <= 10) begin
              $write("mismatch exp c=%h d=%0d col=%0d row=%0d fe=%b", want.color, want.depth,
                     want.column, want.row, want.fend);
              $display(" got c=%h d=%0d col=%0d row=%0d fe=%b", out_color_out, out_depth_out,
                       out_column, out_row, out_frame_end);
            end
          end
        end
      end
      if (!held && pix_sent >= 120 && pending_results.size() > 0) begin
        held = 1;
        hold_left = 100;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sgap > 0) begin
        sgap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (jobs.size() >= 40 && $urandom_range(0, 7) == 0) sgap = $urandom_range(1, 16);
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_write(w3maf_pkg::reg_idx_t idx, logic [15:0] data);
    job_t j;
    j.kind = K_CFG;
    j.idx = idx;
    j.data = data;
    j.color = '0;
    j.depth = '0;
    jobs.push_back(j);
  endtask

  task automatic add_pixel(logic [23:0] c, logic [15:0] d);
    job_t j;
    j.kind = K_PIX;
    j.color = c;
    j.depth = d;
    j.idx = w3maf_pkg::REG_MODE;
    j.data = '0;
    jobs.push_back(j);
  endtask

  function automatic logic [23:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom_range(0, 24'hffffff));
    endcase
  endfunction

  function automatic logic [15:0] rand_depth();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic new_frame(w3maf_pkg::mode_t m, logic [15:0] w, logic [15:0] h);
    add_write(w3maf_pkg::REG_MODE, {14'h0, m});
    add_write(w3maf_pkg::REG_FRAME_WIDTH, w);
    add_write(w3maf_pkg::REG_FRAME_HEIGHT, h);
  endtask

  int total, n, i;
  job_t sync_job;

  initial begin
    sync_job.kind = K_SYNC;
    sync_job.color = '0;
    sync_job.depth = '0;
    sync_job.idx = w3maf_pkg::REG_MODE;
    sync_job.data = '0;

    new_frame(w3maf_pkg::MODE_COLOR_MEDIAN, 16'd3, 16'd3);
    for (i = 0; i < 9; i++) add_pixel(i % 2 ? 24'hffffff : 24'h000000, 16'h0);
    new_frame(w3maf_pkg::MODE_DEPTH_MEDIAN, 16'd0, 16'd2);
    add_pixel(24'h0, 16'h8000);
    add_pixel(24'h0, 16'h7fff);
    new_frame(w3maf_pkg::MODE_DEPTH_AVERAGE, 16'd3, 16'd3);
    add_write(w3maf_pkg::REG_DEPTH_FLOOR, 16'h7fff);
    for (i = 0; i < 9; i++) add_pixel(24'h0, i % 2 ? 16'h7fff : 16'h8000);

    new_frame(w3maf_pkg::MODE_COLOR_AVERAGE, 16'hffff, 16'd1);
    for (i = 0; i < 30; i++) add_pixel(rand_color(), rand_depth());
    new_frame(w3maf_pkg::MODE_DEPTH_MEDIAN, 16'd3, 16'hffff);
    add_write(w3maf_pkg::REG_DEPTH_FLOOR, 16'h8000);
    for (i = 0; i < 30; i++) add_pixel(rand_color(), rand_depth());

    total = 80;
    while (total < 410) begin
      new_frame(w3maf_pkg::mode_t'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                16'($urandom_range(0, 6)));
      if ($urandom_range(0, 1))
        add_write(w3maf_pkg::REG_DEPTH_FLOOR,
                  $urandom_range(0, 2) == 0 ? 16'h8000 : rand_depth());
      n = $urandom_range(10, 40);
      for (i = 0; i < n; i++) begin
        add_pixel(rand_color(), rand_depth());
        if (i == n / 2 && $urandom_range(0, 3) == 0) jobs.push_back(sync_job);
      end
      total += n;
    end
    jobs.push_back(sync_job);
    for (i = 0; i < 20; i++) add_pixel(rand_color(), rand_depth());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (jobs.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
